/* src/bsw_pkg.sv */
package bsw_pkg;

  localparam int unsigned CntW = 7;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               final_res;
    logic               dropped;
  } out_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic            dropped;
  } set_t;

endpackage

/* src/bucket_sort_signed_words.sv */
// Sorts sets of signed 32-bit words into ascending order.
// Input channel: in_valid_i / in_ready_o carrying in_data_i (value, last).
// One word transfers per cycle while loading; last closes the set. Words
// beyond Capacity in a set are discarded and flag dropped on its results.
// Output channel: out_valid_o / out_ready_i carrying out_data_o, one word
// per transfer in ascending order, final_res on the last word of the set.
// Two memory banks hold two sets: the front loads one set while the back
// emits the previous one. in_ready_o falls only when both banks are full.
// The back selects the next word by one scan over the stored set per
// result, reading one word per memory port cycle.
// A stalled receiver holds the output register and the scan waits on it;
// loading continues until both banks are occupied.
// Reset empties both banks and the output register; otherwise only words
// beyond Capacity are lost.
module bucket_sort_signed_words #(
  parameter int unsigned Capacity = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bsw_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bsw_pkg::out_t out_data_o
);
  import bsw_pkg::*;

  localparam int unsigned AddrW = $clog2(Capacity) + 1;

  logic             push, pop, q_full, q_empty, we;
  set_t             push_data, head;
  logic [AddrW-1:0] waddr, raddr;
  logic [31:0]      wdata, rdata;

  bsw_front #(.Capacity(Capacity)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .q_full_i(q_full), .push_o(push), .push_data_o(push_data),
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata)
  );

  bsw_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data),
    .full_o(q_full), .empty_o(q_empty), .pop_i(pop), .head_o(head)
  );

  bsw_ram #(.Width(32), .Depth(2 ** AddrW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  bsw_back #(.Capacity(Capacity)) u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .head_i(head), .pop_o(pop),
    .raddr_o(raddr), .rdata_i(rdata),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule

/* src/bsw_ram.sv */
module bsw_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/bsw_front.sv */
module bsw_front #(
  parameter int unsigned Capacity = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bsw_pkg::in_t                  in_data_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output bsw_pkg::set_t                 push_data_o,
  output logic                          we_o,
  output logic [$clog2(Capacity):0]     waddr_o,
  output logic [31:0]                   wdata_o
);
  import bsw_pkg::*;

  localparam int unsigned IdxW = $clog2(Capacity);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic            bank_q, bank_d;
  logic            full, acc;

  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign full       = cnt_q == CntW'(Capacity);
  assign we_o       = acc && !full;
  assign waddr_o    = {bank_q, cnt_q[IdxW-1:0]};
  assign wdata_o    = in_data_i.value;
  assign push_o     = acc && in_data_i.last;
  assign push_data_o.count   = full ? cnt_q : cnt_q + CntW'(1);
  assign push_data_o.dropped = ovf_q || full;

  always_comb begin
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    bank_d = bank_q;
    if (acc) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
      if (in_data_i.last) begin
        cnt_d  = '0;
        ovf_d  = 1'b0;
        bank_d = !bank_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      bank_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
      bank_q <= bank_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Capacity))
    else $error("front count beyond capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_o |-> !q_full_i)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_o |=> cnt_q == '0)
    else $error("count not cleared after set");

endmodule

/* src/bsw_queue.sv */
module bsw_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bsw_pkg::set_t push_data_i,
  output logic          full_o,
  output logic          empty_o,
  input  logic          pop_i,
  output bsw_pkg::set_t head_o
);
  import bsw_pkg::*;

  set_t       ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] n_q;

  assign full_o  = n_q == 2'd2;
  assign empty_o = n_q == 2'd0;
  assign head_o  = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      n_q  <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i)  rp_q <= !rp_q;
      n_q <= n_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) n_q != 2'd3)
    else $error("queue count invalid");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_q == 2'd0 || n_q == 2'd2) |-> wp_q == rp_q)
    else $error("queue pointers inconsistent");

endmodule

/* src/bsw_back.sv */
module bsw_back #(
  parameter int unsigned Capacity = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  input  bsw_pkg::set_t             head_i,
  output logic                      pop_o,
  output logic [$clog2(Capacity):0] raddr_o,
  input  logic [31:0]               rdata_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output bsw_pkg::out_t             out_data_o
);
  import bsw_pkg::*;

  localparam int unsigned IdxW = $clog2(Capacity);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]         st_q, st_d;
  logic               bank_q, bank_d;
  logic [CntW-1:0]    rj_q, rj_d, pass_q, pass_d;
  logic               rv_q, rv_d;
  logic [IdxW-1:0]    ridx_q, ridx_d;
  logic               found_q, found_d;
  logic signed [31:0] best_q, best_d, prev_q, prev_d;
  logic [IdxW-1:0]    bidx_q, bidx_d, pidx_q, pidx_d;
  logic               ov_q, ov_d;
  out_t               out_q, out_d;
  logic signed [31:0] rd;
  logic               cand, last_pass;

  assign rd        = $signed(rdata_i);
  assign raddr_o   = {bank_q, rj_q[IdxW-1:0]};
  assign last_pass = pass_q == head_i.count - CntW'(1);
  assign cand      = (pass_q == '0) || (rd > prev_q) || (rd == prev_q && ridx_q > pidx_q);
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  always_comb begin
    st_d = st_q; bank_d = bank_q; rj_d = rj_q; pass_d = pass_q;
    rv_d = 1'b0; ridx_d = ridx_q; found_d = found_q;
    best_d = best_q; bidx_d = bidx_q; prev_d = prev_q; pidx_d = pidx_q;
    ov_d = ov_q && !out_ready_i; out_d = out_q; pop_o = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (!q_empty_i) begin
          st_d = StScan; rj_d = '0; pass_d = '0; found_d = 1'b0;
        end
      end
      StScan: begin
        if (rj_q != head_i.count) begin
          rv_d = 1'b1; ridx_d = rj_q[IdxW-1:0]; rj_d = rj_q + CntW'(1);
        end else if (!rv_q) begin
          st_d = StEmit;
        end
        if (rv_q && cand && (!found_q || rd < best_q)) begin
          found_d = 1'b1; best_d = rd; bidx_d = ridx_q;
        end
      end
      StEmit: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          out_d.sorted_value = best_q;
          out_d.final_res    = last_pass;
          out_d.dropped      = head_i.dropped;
          prev_d = best_q; pidx_d = bidx_q;
          pass_d = pass_q + CntW'(1);
          rj_d = '0; found_d = 1'b0;
          if (last_pass) begin
            pop_o = 1'b1; bank_d = !bank_q; st_d = StIdle;
          end else begin
            st_d = StScan;
          end
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d; bidx_q <= bidx_d; prev_q <= prev_d; pidx_q <= pidx_d;
    ridx_q <= ridx_d; out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; bank_q <= 1'b0; rj_q <= '0; pass_q <= '0;
      rv_q <= 1'b0; found_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; bank_q <= bank_d; rj_q <= rj_d; pass_q <= pass_d;
      rv_q <= rv_d; found_q <= found_d; ov_q <= ov_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) st_q == StEmit |-> found_q)
    else $error("emit without a selected element");
  assert property (@(posedge clk_i) disable iff (!rst_ni) st_q != StIdle |-> !q_empty_i)
    else $error("sorting without a loaded set");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (!ov_q || out_ready_i))
    else $error("set released with result still pending");

endmodule

/* tb/bucket_sort_signed_words_tb.sv */
`timescale 1ns / 1ps

module bucket_sort_signed_words_tb;
  import bsw_pkg::*;

  localparam int unsigned Capacity = 64;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  bucket_sort_signed_words #(.Capacity(Capacity)) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  in_t  pending_words[$];
  int   pending_gaps[$];
  out_t sorted_expected[$];

  logic signed [31:0] set_words[$];
  logic               set_overflow = 1'b0;
  int                 words_sent;
  int                 errors = 0;
  bit                 stimulus_done = 1'b0;
  int                 hold_off;
  bit                 hold_req = 1'b0;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic void sort_set(input bit ovf);
    logic signed [31:0] w[$];
    logic signed [31:0] t;
    int n;
    out_t r;
    w = set_words;
    n = w.size();
    for (int i = 1; i < n; i++) begin
      t = w[i];
      for (int k = i; k > 0 && w[k-1] > t; k--) begin
        w[k] = w[k-1];
        w[k-1] = t;
      end
    end
    for (int i = 0; i < n; i++) begin
      r.sorted_value = w[i];
      r.final_res    = (i == n - 1);
      r.dropped      = ovf;
      sorted_expected.insert(sorted_expected.size(), r);
    end
  endfunction

  function automatic void load_word(input in_t it);
    if (set_words.size() < Capacity) set_words.insert(set_words.size(), it.value);
    else set_overflow = 1'b1;
    if (it.last) begin
      sort_set(set_overflow);
      set_words.delete();
      set_overflow = 1'b0;
    end
  endfunction

  task automatic queue_word(input logic signed [31:0] v, input logic l, input int gap);
    in_t it;
    it.value = v;
    it.last  = l;
    pending_words.insert(pending_words.size(), it);
    pending_gaps.insert(pending_gaps.size(), gap);
  endtask

  function automatic logic signed [31:0] rand_word(input int mode, input int base);
    case (mode)
      0: rand_word = $urandom;
      1: rand_word = base + $urandom_range(0, 8);
      2: rand_word = ($urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 3)
                                           : 32'sh80000000 + $urandom_range(0, 3));
      default: rand_word = $signed($urandom_range(0, 40)) - 20;
    endcase
  endfunction

  task automatic queue_set(input int n, input bit idle);
    int mode;
    int base;
    mode = $urandom_range(0, 3);
    base = $urandom;
    for (int i = 0; i < n; i++)
      queue_word(rand_word(mode, base), i == n - 1, idle ? $urandom_range(0, 14) : 0);
  endtask

  int n;

  initial begin
    queue_word(32'sh7fffffff, 1'b1, 0);
    queue_word(32'sh80000000, 1'b1, 0);
    queue_word(32'sh7fffffff, 1'b0, 0);
    queue_word(32'sh80000000, 1'b0, 0);
    queue_word(32'sd0, 1'b0, 0);
    queue_word(-32'sd1, 1'b1, 0);
    for (int i = 0; i < 4; i++) queue_word(32'sd5, i == 3, 1);
    queue_word(32'sd3, 1'b0, 0);
    queue_word(32'sd1, 1'b0, 0);
    queue_word(32'sd2, 1'b0, 0);
    queue_word(32'sd3, 1'b1, 0);
    queue_word(32'sh55555555, 1'b0, 0);
    queue_word(32'shaaaaaaaa, 1'b0, 0);
    queue_word(32'sh7ffffffe, 1'b1, 0);
    queue_set(Capacity, 1'b0);
    queue_set(Capacity + 3, 1'b0);
    pending_gaps[pending_gaps.size() - 1] = -1;
    while (pending_words.size() < 460) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
      queue_set(n, $urandom_range(0, 3) != 0);
    end
    queue_word($urandom, 1'b1, 0);
  end

  int   in_wait;
  int   cur_gap;
  bit   drain_wait;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      in_wait    <= 0;
      drain_wait <= 1'b0;
      words_sent <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        load_word(in_data_i);
        words_sent <= words_sent + 1;
        if (cur_gap < 0) drain_wait <= 1'b1;
        else if (cur_gap > 0) in_wait <= cur_gap - 1;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (drain_wait || (in_valid_i && in_ready_o && cur_gap < 0)) begin
          in_valid_i <= 1'b0;
          if (drain_wait && sorted_expected.size() == 0) drain_wait <= 1'b0;
        end else if (in_valid_i && in_ready_o && cur_gap > 0) begin
          in_valid_i <= 1'b0;
        end else if (!(in_valid_i && in_ready_o) && in_wait > 0) begin
          in_valid_i <= 1'b0;
          in_wait <= in_wait - 1;
        end else if (pending_words.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_words.pop_front();
          cur_gap    = pending_gaps.pop_front();
        end else begin
          in_valid_i <= 1'b0;
          stimulus_done <= 1'b1;
        end
      end
    end
  end

  int out_wait;

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_wait    <= 0;
      hold_off    <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (sorted_expected.size() == 0) begin
          $error("unexpected result: sorted_value %0d", out_data_o.sorted_value);
          errors++;
        end else begin
          want = sorted_expected.pop_front();
          if (out_data_o.sorted_value !== want.sorted_value) begin
            $error("sorted_value expected %0d actual %0d", want.sorted_value,
                   out_data_o.sorted_value);
            errors++;
          end
          if (out_data_o.final_res !== want.final_res) begin
            $error("final_res expected %0b actual %0b", want.final_res, out_data_o.final_res);
            errors++;
          end
          if (out_data_o.dropped !== want.dropped) begin
            $error("dropped expected %0b actual %0b", want.dropped, out_data_o.dropped);
            errors++;
          end
        end
      end
      if (words_sent == 20 && hold_off == 0 && !hold_req) begin
        hold_req <= 1'b1;
        hold_off <= 3000;
        out_ready_i <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready_i <= 1'b0;
      end else if (out_valid_o && out_ready_i || !out_ready_i && out_wait == 0) begin
        if (out_valid_o && out_ready_i) begin
          out_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
          out_ready_i <= ($urandom_range(0, 2) == 0);
        end else begin
          out_ready_i <= 1'b1;
        end
      end else if (!out_ready_i) begin
        out_wait <= out_wait - 1;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (stimulus_done && sorted_expected.size() == 0);
    repeat (500) @(posedge clk_i);
    if (errors == 0 && sorted_expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(12 * 2_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sim.f */
src/bsw_pkg.sv
src/bsw_ram.sv
src/bsw_front.sv
src/bsw_queue.sv
src/bsw_back.sv
src/bucket_sort_signed_words.sv
tb/bucket_sort_signed_words_tb.sv
